/* src/bxavg_pkg.sv */
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared types and constants for the box-average downscaler.
// ----------------------------------------------------------------------------
package bxavg_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_FACTOR = 16;

    localparam int SAMPLE_W  = 8;
    localparam int SUM_W     = 16;
    localparam int MEAN_W    = 8;
    localparam int CFG_W_W   = 12;
    localparam int CFG_H_W   = 13;
    localparam int CFG_K_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int ROW_W     = 12;
    localparam int HEIGHT_LIMIT = 4096;

    // Reciprocal scale: exact floor division of a 16-bit sum by any k*k up to 4096.
    localparam int DIV_SHIFT = 28;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam logic [CFG_W_W-1:0] RST_WIDTH  = CFG_W_W'(640);
    localparam logic [CFG_H_W-1:0] RST_HEIGHT = CFG_H_W'(480);
    localparam logic [CFG_K_W-1:0] RST_FACTOR = CFG_K_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FACTOR = 2'd2;

    typedef struct packed {
        logic accept;
        logic sum_en;
        logic mul_en;
        logic out_load;
    } bxavg_cmd_t;

    typedef struct packed {
        logic in_block;
        logic emit;
        logic out_busy;
    } bxavg_stat_t;

endpackage

/* src/box_average_downscale.sv */
// A sample outside every block does not hold the input. One inside a block
// holds it for the line store read-modify-write; the one that completes a
// block also for the reciprocal multiply and the load of its mean into the
// output register, and longer while that register is full. Reset (aresetn,
// synchronous) restores 640 x 480, k = 2, clears all counters and m_valid;
// the block sum store is not cleared.
// ----------------------------------------------------------------------------
// box_average_downscale
// Downscales one 8-bit image component by averaging k-by-k pixel blocks.
// ----------------------------------------------------------------------------
module box_average_downscale import bxavg_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic                  s_frame_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MEAN_W-1:0]     m_mean_value,
    output logic                  m_row_end,
    output logic                  m_frame_end
);

    bxavg_cmd_t  cmd;
    bxavg_stat_t stat;

    bxavg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bxavg_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_sample      (s_sample),
        .s_frame_start (s_frame_start),
        .cmd           (cmd),
        .stat          (stat),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_mean_value  (m_mean_value),
        .m_row_end     (m_row_end),
        .m_frame_end   (m_frame_end)
    );

endmodule

/* src/bxavg_ctrl.sv */
// ----------------------------------------------------------------------------
// bxavg_ctrl
// Sequencer for one item: line store update, reciprocal multiply, output load.
// ----------------------------------------------------------------------------
module bxavg_ctrl import bxavg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bxavg_stat_t stat,
    output bxavg_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready      = (state_reg == ST_IDLE);
    assign cmd.accept   = s_valid && s_ready;
    assign cmd.sum_en   = (state_reg == ST_SUM);
    assign cmd.mul_en   = (state_reg == ST_MUL);
    assign cmd.out_load = (state_reg == ST_OUT) && !stat.out_busy;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && stat.in_block) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                state_next = stat.emit ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.out_busy)
        else $error("Result loaded while the output register still holds an item.");

    a_mul_follows_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sum_en |=> (cmd.mul_en == $past(stat.emit)))
        else $error("Multiply step does not follow a block-completing item.");

    a_outside_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && !stat.in_block) |=> s_ready)
        else $error("An item outside every block held the input side.");

endmodule

/* src/bxavg_datapath.sv */
// ----------------------------------------------------------------------------
// bxavg_datapath
// Configuration, raster counters, block sum line store, reciprocal divider
// and output register.
// ----------------------------------------------------------------------------
module bxavg_datapath import bxavg_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic                  s_frame_start,
    input  bxavg_cmd_t            cmd,
    output bxavg_stat_t           stat,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic [MEAN_W-1:0]     m_mean_value,
    output logic                  m_row_end,
    output logic                  m_frame_end
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int KW  = $clog2(MAX_FACTOR);
    localparam int KEW = $clog2(MAX_FACTOR + 1);
    localparam int XW  = ((CW > CFG_W_W) ? CW : CFG_W_W) + 2;
    localparam int YW  = CFG_H_W + 2;
    localparam int KX  = ((KEW > CFG_K_W) ? KEW : CFG_K_W) + 1;

    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic [CFG_K_W-1:0] factor_reg;

    logic [XW-1:0]  w_ext, w_eff;
    logic [YW-1:0]  h_ext, h_eff;
    logic [KX-1:0]  k_ext, k_cl;
    logic [KEW-1:0] k_eff;

    logic [CW-1:0]    cc_reg, cc_cur, cc_next;
    logic [ROW_W-1:0] rc_reg, rc_cur, rc_next;
    logic [KW-1:0]    cib_reg, cib_cur, cib_next;
    logic [KW-1:0]    rib_reg, rib_cur, rib_next;
    logic [CW-1:0]    oc_reg, oc_cur, oc_next;

    logic in_col, in_row, in_block, cib_last, rib_last, emit, last_col, last_row;
    logic restart;

    logic [SUM_W-1:0]    mem [MAX_WIDTH];
    logic [SUM_W-1:0]    rd_data_reg;
    logic [CW-1:0]       idx_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                first_reg;
    logic                emit_reg;
    logic                last_col_reg;
    logic                last_row_reg;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    sum_reg;
    logic [RECIP_W-1:0]  recip_tab [MAX_FACTOR + 1];
    logic [RECIP_W-1:0]  recip_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                valid_reg;
    logic [MEAN_W-1:0]   mean_reg;
    logic                row_end_reg;
    logic                frame_end_reg;

    for (genvar g = 0; g <= MAX_FACTOR; g++) begin : g_recip
        localparam longint unsigned D = (g == 0) ? 1 : g * g;
        localparam longint unsigned R = ((64'd1 << DIV_SHIFT) + D - 1) / D;
        assign recip_tab[g] = RECIP_W'(R);
    end

    assign w_ext = XW'(width_reg);
    assign w_eff = (w_ext == '0) ? XW'(1) :
                   (w_ext > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : w_ext;
    assign h_ext = YW'(height_reg);
    assign h_eff = (h_ext == '0) ? YW'(1) :
                   (h_ext > YW'(HEIGHT_LIMIT)) ? YW'(HEIGHT_LIMIT) : h_ext;
    assign k_ext = KX'(factor_reg);
    assign k_cl  = (k_ext == '0) ? KX'(1) :
                   (k_ext > KX'(MAX_FACTOR)) ? KX'(MAX_FACTOR) : k_ext;
    assign k_eff = k_cl[KEW-1:0];

    assign cc_cur  = s_frame_start ? '0 : cc_reg;
    assign rc_cur  = s_frame_start ? '0 : rc_reg;
    assign cib_cur = s_frame_start ? '0 : cib_reg;
    assign rib_cur = s_frame_start ? '0 : rib_reg;
    assign oc_cur  = s_frame_start ? '0 : oc_reg;

    // A sample lies in a block when that whole block fits inside the image.
    assign in_col   = (XW'(cc_cur) - XW'(cib_cur) + XW'(k_eff)) <= w_eff;
    assign in_row   = (YW'(rc_cur) - YW'(rib_cur) + YW'(k_eff)) <= h_eff;
    assign in_block = in_col && in_row;
    assign cib_last = (KX'(cib_cur) + KX'(1)) >= KX'(k_eff);
    assign rib_last = (KX'(rib_cur) + KX'(1)) >= KX'(k_eff);
    assign emit     = in_block && cib_last && rib_last;
    assign last_col = (XW'(cc_cur) + XW'(1) + XW'(k_eff)) > w_eff;
    assign last_row = (YW'(rc_cur) + YW'(1) + YW'(k_eff)) > h_eff;

    always_comb begin
        cc_next  = cc_cur;
        rc_next  = rc_cur;
        cib_next = cib_cur;
        rib_next = rib_cur;
        oc_next  = oc_cur;
        if (in_block) begin
            if (cib_last) begin
                cib_next = '0;
                oc_next  = oc_cur + CW'(1);
            end else begin
                cib_next = cib_cur + KW'(1);
            end
        end
        if ((XW'(cc_cur) + XW'(1)) >= w_eff) begin
            cc_next  = '0;
            cib_next = '0;
            oc_next  = '0;
            if ((YW'(rc_cur) + YW'(1)) >= h_eff) begin
                rc_next  = '0;
                rib_next = '0;
            end else begin
                rc_next  = rc_cur + ROW_W'(1);
                rib_next = rib_last ? '0 : rib_cur + KW'(1);
            end
        end else begin
            cc_next = cc_cur + CW'(1);
        end
    end

    assign restart = cfg_we && ((cfg_index == CFG_IDX_WIDTH) ||
                                (cfg_index == CFG_IDX_HEIGHT) ||
                                (cfg_index == CFG_IDX_FACTOR));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            factor_reg <= RST_FACTOR;
            cc_reg     <= '0;
            rc_reg     <= '0;
            cib_reg    <= '0;
            rib_reg    <= '0;
            oc_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_IDX_WIDTH:  width_reg  <= cfg_wdata[CFG_W_W-1:0];
                    CFG_IDX_HEIGHT: height_reg <= cfg_wdata[CFG_H_W-1:0];
                    CFG_IDX_FACTOR: factor_reg <= cfg_wdata[CFG_K_W-1:0];
                    default: begin
                    end
                endcase
            end
            priority if (restart) begin
                cc_reg  <= '0;
                rc_reg  <= '0;
                cib_reg <= '0;
                rib_reg <= '0;
                oc_reg  <= '0;
            end else if (cmd.accept) begin
                cc_reg  <= cc_next;
                rc_reg  <= rc_next;
                cib_reg <= cib_next;
                rib_reg <= rib_next;
                oc_reg  <= oc_next;
            end else begin
            end
        end
    end

    assign sum = first_reg ? SUM_W'(sample_reg) : rd_data_reg + SUM_W'(sample_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_data_reg <= mem[oc_cur];
        end
        if (cmd.sum_en) begin
            mem[idx_reg] <= sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            idx_reg      <= oc_cur;
            sample_reg   <= s_sample;
            first_reg    <= (cib_cur == '0) && (rib_cur == '0);
            last_col_reg <= last_col;
            last_row_reg <= last_row;
        end
        if (cmd.sum_en) begin
            sum_reg   <= sum;
            recip_reg <= recip_tab[k_eff];
        end
        if (cmd.mul_en) begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(recip_reg);
        end
        if (cmd.out_load) begin
            mean_reg      <= prod_reg[DIV_SHIFT +: MEAN_W];
            row_end_reg   <= last_col_reg;
            frame_end_reg <= last_col_reg && last_row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                emit_reg <= emit;
            end
            if (cmd.out_load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign stat.in_block = in_block;
    assign stat.emit     = emit_reg;
    assign stat.out_busy = valid_reg && !m_ready;

    assign m_valid      = valid_reg;
    assign m_mean_value = mean_reg;
    assign m_row_end    = row_end_reg;
    assign m_frame_end  = frame_end_reg;

endmodule

/* verif/box_average_downscale_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_downscale_test
// Self-checking testbench for the box-average downscaler. Samples are sent
// over a valid/ready channel. An in-bench model of the block sums and
// counters predicts each block mean with its row and frame end flags, and
// every result leaving the block is compared with the oldest prediction.
// Directed frames cover the geometry corner cases and the mean extremes.
// Random frames run under three back-pressure mixes.
// ----------------------------------------------------------------------------
module box_average_downscale_test;
    import bxavg_pkg::*;

    localparam int MAX_WIDTH  = DEF_MAX_WIDTH;
    localparam int MAX_FACTOR = DEF_MAX_FACTOR;
    localparam int SLOT_W     = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              row_end;
        logic              frame_end;
    } mean_result_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_IDX_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample      = '0;
    logic                  s_frame_start = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [MEAN_W-1:0]     m_mean_value;
    logic                  m_row_end;
    logic                  m_frame_end;

    // Model of the block's configuration, line store and raster position.
    logic [CFG_W_W-1:0] reg_width  = RST_WIDTH;
    logic [CFG_H_W-1:0] reg_height = RST_HEIGHT;
    logic [CFG_K_W-1:0] reg_factor = RST_FACTOR;
    logic [SUM_W-1:0]   line_sums [MAX_WIDTH];
    int unsigned        col_pos    = 0;
    int unsigned        row_pos    = 0;
    int unsigned        col_in_box = 0;
    int unsigned        row_in_box = 0;
    int unsigned        out_col    = 0;

    mean_result_t expected_means[$];
    int unsigned  sent_total    = 0;
    int unsigned  failures      = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    box_average_downscale dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mean_value  (m_mean_value),
        .m_row_end     (m_row_end),
        .m_frame_end   (m_frame_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void effective_dims(output int unsigned w, h, k);
        w = 32'(reg_width);
        h = 32'(reg_height);
        k = 32'(reg_factor);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h == 0) h = 1;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        if (k == 0) k = 1;
        if (k > MAX_FACTOR) k = MAX_FACTOR;
    endfunction

    function automatic void restart_counters();
        col_pos    = 0;
        row_pos    = 0;
        col_in_box = 0;
        row_in_box = 0;
        out_col    = 0;
    endfunction

    function automatic void predict_downscale(input logic [SAMPLE_W-1:0] smp, input logic fs);
        int unsigned       w, h, k, out_w, out_h;
        logic [SLOT_W-1:0] slot;
        logic [SUM_W-1:0]  total;
        mean_result_t      res;
        effective_dims(w, h, k);
        out_w = w / k;
        out_h = h / k;
        if (fs) restart_counters();
        if (col_pos < out_w * k && row_pos < out_h * k) begin
            slot = SLOT_W'(out_col % MAX_WIDTH);
            if (col_in_box == 0 && row_in_box == 0) begin
                total = SUM_W'(smp);
            end else begin
                total = line_sums[slot] + SUM_W'(smp);
            end
            line_sums[slot] = total;
            if (col_in_box + 1 >= k && row_in_box + 1 >= k) begin
                res.mean      = MEAN_W'(total / (k * k));
                res.row_end   = (out_col + 1 >= out_w);
                res.frame_end = res.row_end && (row_pos + 1 >= out_h * k);
                expected_means.push_back(res);
            end
            if (col_in_box + 1 >= k) begin
                col_in_box = 0;
                out_col++;
            end else begin
                col_in_box++;
            end
        end
        if (col_pos + 1 >= w) begin
            col_pos    = 0;
            col_in_box = 0;
            out_col    = 0;
            if (row_pos + 1 >= h) begin
                row_pos    = 0;
                row_in_box = 0;
            end else begin
                row_pos++;
                if (row_in_box + 1 >= k) row_in_box = 0;
                else row_in_box++;
            end
        end else begin
            col_pos++;
        end
    endfunction

    always @(posedge aclk) begin : check_means
        mean_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_means.size() == 0) begin
                $error("unexpected item: mean_value %0d row_end %0b frame_end %0b",
                       m_mean_value, m_row_end, m_frame_end);
                failures++;
            end else begin
                want = expected_means.pop_front();
                if (m_mean_value !== want.mean) begin
                    $error("mean_value: expected %0d, actual %0d", want.mean, m_mean_value);
                    failures++;
                end
                if (m_row_end !== want.row_end) begin
                    $error("row_end: expected %0b, actual %0b", want.row_end, m_row_end);
                    failures++;
                end
                if (m_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", want.frame_end, m_frame_end);
                    failures++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample      <= smp;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        predict_downscale(smp, fs);
        sent_total++;
    endtask

    task automatic send_constant(input logic [SAMPLE_W-1:0] smp, input int unsigned count,
                                 input logic fs_first);
        for (int unsigned n = 0; n < count; n++) send_sample(smp, (n == 0) ? fs_first : 1'b0);
    endtask

    task automatic send_random_run(input int unsigned count, input logic fs_first);
        for (int unsigned n = 0; n < count; n++) begin
            send_sample(SAMPLE_W'($urandom_range(255)), (n == 0) ? fs_first : 1'b0);
        end
    endtask

    // Every expected mean has arrived and the last item has left the pipeline.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_IDX_WIDTH:  reg_width  = val[CFG_W_W-1:0];
            CFG_IDX_HEIGHT: reg_height = val[CFG_H_W-1:0];
            CFG_IDX_FACTOR: reg_factor = val[CFG_K_W-1:0];
            default: ;
        endcase
        restart_counters();
    endtask

    task automatic configure_image(input logic [CFG_DATA_W-1:0] w, h, k);
        drain_results();
        set_reg(CFG_IDX_WIDTH, w);
        set_reg(CFG_IDX_HEIGHT, h);
        set_reg(CFG_IDX_FACTOR, k);
        cfg_we <= 1'b0;
    endtask

    // At the reset geometry the first row of a frame yields no result.
    task automatic test_reset_geometry();
        send_random_run(16, 1'b0);
    endtask

    task automatic test_mean_extremes();
        configure_image(4, 2, 2);
        send_constant(8'h00, 8, 1'b1);
        send_constant(8'hFF, 8, 1'b1);
    endtask

    task automatic test_floor_division();
        configure_image(3, 3, 3);
        send_constant(8'h01, 8, 1'b1);
        send_sample(8'h00, 1'b0);
        send_constant(8'hFF, 8, 1'b1);
        send_sample(8'hFE, 1'b0);
    endtask

    task automatic test_largest_block();
        configure_image(16, 16, 31);
        send_constant(8'hFF, 256, 1'b1);
    endtask

    task automatic test_degenerate_geometry();
        configure_image(0, 0, 0);
        send_random_run(2, 1'b1);
        send_random_run(2, 1'b0);
        configure_image(4096, 1, 1);
        send_random_run(3, 1'b0);
    endtask

    task automatic test_oversized_factor();
        configure_image(3, 8, 4);
        send_random_run(24, 1'b1);
        configure_image(8, 3, 4);
        send_random_run(24, 1'b0);
    endtask

    task automatic test_frame_restart();
        configure_image(6, 4, 2);
        send_random_run(7, 1'b0);
        send_random_run(24, 1'b1);
        send_random_run(24, 1'b0);
    endtask

    task automatic test_width_saturation();
        configure_image(4095, 1, 1);
        send_random_run(24, 1'b1);
    endtask

    task automatic test_height_saturation();
        configure_image(1, 8191, 1);
        send_random_run(16, 1'b1);
    endtask

    task automatic test_random_frames(input int unsigned item_goal);
        int unsigned           goal_mark, w, h, k, length;
        logic [CFG_DATA_W-1:0] wv, hv, kv;
        logic                  fs_next;
        logic [SAMPLE_W-1:0]   smp;
        goal_mark = sent_total + item_goal;
        while (sent_total < goal_mark) begin
            case ($urandom_range(19))
                0:       wv = '0;
                1:       wv = CFG_DATA_W'($urandom_range(17, 40));
                default: wv = CFG_DATA_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(19))
                0:       hv = '0;
                1:       hv = CFG_DATA_W'($urandom_range(16, 24));
                default: hv = CFG_DATA_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(19))
                0:       kv = '0;
                1:       kv = CFG_DATA_W'($urandom_range(16, 31));
                2:       kv = CFG_DATA_W'($urandom_range(5, 15));
                default: kv = CFG_DATA_W'($urandom_range(1, 4));
            endcase
            configure_image(wv, hv, kv);
            effective_dims(w, h, k);
            fs_next = 1'($urandom_range(1));
            repeat ($urandom_range(1, 3)) begin
                length = w * h;
                if ($urandom_range(99) < 8) length = $urandom_range(1, length);
                for (int unsigned n = 0; n < length && sent_total < goal_mark; n++) begin
                    if ($urandom_range(9) == 0) smp = $urandom_range(1) ? 8'hFF : 8'h00;
                    else smp = SAMPLE_W'($urandom_range(255));
                    send_sample(smp, (n == 0) ? fs_next : ($urandom_range(99) < 2));
                end
                fs_next = (length != w * h) || ($urandom_range(1) != 0);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 16;
        recv_idle_pct = 79;
        test_reset_geometry();
        test_mean_extremes();
        test_floor_division();
        test_largest_block();
        test_degenerate_geometry();
        test_oversized_factor();
        test_frame_restart();
        test_random_frames(32);
        send_idle_pct = 79;
        recv_idle_pct = 16;
        test_random_frames(32);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(32);
        test_width_saturation();
        test_height_saturation();
        drain_results();
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/bxavg_pkg.sv
src/bxavg_ctrl.sv
src/bxavg_datapath.sv
src/box_average_downscale.sv
verif/box_average_downscale_test.sv
